[hdl/pes_pkg.sv]
`default_nettype none
package pes_pkg;

  // Default geometry
  localparam int ROWS_DEF    = 1024;
  localparam int COLUMNS_DEF = 1024;

  // Row and column compare width: covers the largest legal parameter value
  localparam int EXT_W = 13;

  // Field widths
  localparam int PIX_W  = 10;
  localparam int ATTR_W = 32;
  localparam int MODE_W = 2;

  // Operation codes of the mode field
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // Register indexes
  localparam int REG_ATTR_SET = 0;

  // Store write control from the edge walker
  typedef struct packed {
    logic en;     // write this cycle
    logic left;   // left side stores, else right
    logic uv;     // u and v stores enabled
    logic inten;  // intensity store enabled
  } pes_wr_t;

endpackage
`default_nettype wire

[hdl/polygon_edge_scanner_unit.sv]
`default_nettype none
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | mode, end points, attributes, read_row
// out     | output    | out_valid / out_ready| span rows, left and right store fields
// cfg     | input     | APB psel/penable     | attribute_set at byte address 0
//
// Scan edge: three divisions in the shared divider, then a walk along the
// major axis. Read row: one registered store read. Start polygon and
// horizontal edge: straight to the output word. Reset is synchronous; stores
// are not cleared.
// A pending word on out holds the sequencer in its last state; in_ready is low
// while an item is in work.
module polygon_edge_scanner_unit #(
  parameter int ROWS    = pes_pkg::ROWS_DEF,
  parameter int COLUMNS = pes_pkg::COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [9:0]  x_start,
  input  wire logic [9:0]  y_start,
  input  wire logic [9:0]  x_end,
  input  wire logic [9:0]  y_end,
  input  wire logic [31:0] u_start,
  input  wire logic [31:0] v_start,
  input  wire logic [31:0] i_start,
  input  wire logic [31:0] u_end,
  input  wire logic [31:0] v_end,
  input  wire logic [31:0] i_end,
  input  wire logic [9:0]  read_row,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       span_top,
  output logic [9:0]       span_bottom,
  output logic [9:0]       left_col,
  output logic [9:0]       right_col,
  output logic [31:0]      left_u,
  output logic [31:0]      left_v,
  output logic [31:0]      left_i,
  output logic [31:0]      right_u,
  output logic [31:0]      right_v,
  output logic [31:0]      right_i,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DGO  = 3'd1;
  localparam logic [2:0] S_DWT  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [pes_pkg::EXT_W-1:0] ROW_LIM = pes_pkg::EXT_W'(ROWS);

  logic [2:0]  state;
  logic [1:0]  attribute_set;
  logic [9:0]  top_row;
  logic [9:0]  bottom_row;

  // latched item
  logic [1:0]  op;
  logic [9:0]  rrow;
  logic [31:0] us, vs, is_, ue, ve, ie;
  logic [9:0]  x, y, x2, y2;
  logic [9:0]  adx, dy, major;
  logic        left, sx_neg, xmaj, last_mode, first;
  logic signed [11:0] err;
  logic [31:0] au, av, ai, du, dv, di;
  logic [1:0]  div_idx;

  // accept-time edge setup
  logic        in_acc;
  logic        dxn;
  logic [9:0]  adx_in, dy_in;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign dxn      = x_end < x_start;
  assign adx_in   = dxn ? (x_start - x_end) : (x_end - x_start);
  assign dy_in    = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(pes_pkg::REG_ATTR_SET)) ? {30'd0, attribute_set} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_set <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'(pes_pkg::REG_ATTR_SET)) begin
      attribute_set <= pwdata[1:0];
    end
  end

  // shared divider
  logic        div_start, div_done;
  logic [32:0] div_num;
  logic [31:0] div_q;

  always_comb begin
    case (div_idx)
      2'd0:    div_num = {ue[31], ue} - {us[31], us};
      2'd1:    div_num = {ve[31], ve} - {vs[31], vs};
      default: div_num = {ie[31], ie} - {is_[31], is_};
    endcase
  end
  assign div_start = (state == S_DGO);

  pes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (major),
    .done     (div_done),
    .quotient (div_q)
  );

  // walk step logic
  logic [9:0]  xn, yn;
  logic [31:0] aun, avn, ain;
  logic signed [11:0] ex, ey;
  logic        at_end;
  pes_pkg::pes_wr_t wr;
  logic        put_next;

  assign xn     = sx_neg ? (x - 10'd1) : (x + 10'd1);
  assign yn     = left ? (y - 10'd1) : (y + 10'd1);
  assign aun    = au + du;
  assign avn    = av + dv;
  assign ain    = ai + di;
  assign ex     = err - $signed({2'b0, dy});
  assign ey     = err - $signed({2'b0, adx});
  assign at_end = xmaj ? (x == x2) : (y == y2);

  always_comb begin
    wr.left  = left;
    wr.uv    = attribute_set[1];
    wr.inten = attribute_set[0];
    wr.en    = 1'b0;
    put_next = 1'b0;
    if (state == S_WALK) begin
      if (xmaj && last_mode) begin
        wr.en = at_end || (ex < 0);
      end else if (xmaj) begin
        wr.en    = first || (!at_end && ex < 0);
        put_next = !first;
      end else begin
        wr.en = 1'b1;
      end
    end
  end

  logic [9:0]  rd_lx, rd_rx;
  logic [31:0] rd_lu, rd_lv, rd_li, rd_ru, rd_rv, rd_ri;

  pes_store #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_store (
    .clk    (clk),
    .wr     (wr),
    .wr_row (put_next ? yn : y),
    .wr_col (put_next ? xn : x),
    .wr_u   (put_next ? aun : au),
    .wr_v   (put_next ? avn : av),
    .wr_i   (put_next ? ain : ai),
    .rd_en  (state == S_READ),
    .rd_row (rrow),
    .rd_lx  (rd_lx),
    .rd_rx  (rd_rx),
    .rd_lu  (rd_lu),
    .rd_lv  (rd_lv),
    .rd_li  (rd_li),
    .rd_ru  (rd_ru),
    .rd_rv  (rd_rv),
    .rd_ri  (rd_ri)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top_row    <= '0;
      bottom_row <= '0;
      div_idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (mode)
              pes_pkg::MODE_SCAN: begin
                if (y_end < top_row) top_row <= y_end;
                else if (y_end > bottom_row) bottom_row <= y_end;
                div_idx <= '0;
                state   <= (y_start == y_end) ? S_DONE : S_DGO;
              end
              pes_pkg::MODE_READ: state <= S_READ;
              pes_pkg::MODE_START: begin
                top_row    <= y_start;
                bottom_row <= y_start;
                state      <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DGO: state <= S_DWT;
        S_DWT: begin
          if (div_done) begin
            div_idx <= div_idx + 2'd1;
            state   <= (div_idx == 2'd2) ? S_WALK : S_DGO;
          end
        end
        S_WALK: begin
          if (xmaj && !last_mode) begin
            if (!first && at_end) state <= S_DONE;
          end else if (at_end) begin
            state <= S_DONE;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op        <= mode;
      rrow      <= read_row;
      us        <= u_start;
      vs        <= v_start;
      is_       <= i_start;
      ue        <= u_end;
      ve        <= v_end;
      ie        <= i_end;
      x         <= x_start;
      y         <= y_start;
      x2        <= x_end;
      y2        <= y_end;
      adx       <= adx_in;
      dy        <= dy_in;
      major     <= (adx_in > dy_in) ? adx_in : dy_in;
      left      <= y_start > y_end;
      sx_neg    <= dxn;
      xmaj      <= adx_in > dy_in;
      last_mode <= (y_start > y_end) == dxn;
      first     <= 1'b1;
      err       <= (adx_in > dy_in) ? $signed({3'b0, adx_in[9:1]})
                                    : $signed({3'b0, dy_in[9:1]});
      au        <= u_start;
      av        <= v_start;
      ai        <= i_start;
    end else if (state == S_DWT && div_done) begin
      case (div_idx)
        2'd0:    du <= div_q;
        2'd1:    dv <= div_q;
        default: di <= div_q;
      endcase
    end else if (state == S_WALK && !at_end) begin
      if (xmaj && last_mode) begin
        if (ex < 0) begin
          err <= ex + $signed({2'b0, adx});
          y   <= yn;
        end else begin
          err <= ex;
        end
        x <= xn; au <= aun; av <= avn; ai <= ain;
      end else if (xmaj) begin
        if (first) begin
          first <= 1'b0;
        end else begin
          if (ex < 0) begin
            err <= ex + $signed({2'b0, adx});
            y   <= yn;
          end else begin
            err <= ex;
          end
          x <= xn; au <= aun; av <= avn; ai <= ain;
        end
      end else begin
        if (ey < 0) begin
          err <= ey + $signed({2'b0, dy});
          x   <= xn;
        end else begin
          err <= ey;
        end
        y <= yn; au <= aun; av <= avn; ai <= ain;
      end
    end else if (state == S_WALK && first) begin
      first <= 1'b0;
    end
  end

  // output word register
  logic rd_ok;
  assign rd_ok = (op == pes_pkg::MODE_READ)
              && ({{(pes_pkg::EXT_W-10){1'b0}}, rrow} < ROW_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      span_top    <= top_row;
      span_bottom <= bottom_row;
      left_col    <= rd_ok ? rd_lx : '0;
      right_col   <= rd_ok ? rd_rx : '0;
      left_u      <= rd_ok ? rd_lu : '0;
      left_v      <= rd_ok ? rd_lv : '0;
      left_i      <= rd_ok ? rd_li : '0;
      right_u     <= rd_ok ? rd_ru : '0;
      right_v     <= rd_ok ? rd_rv : '0;
      right_i     <= rd_ok ? rd_ri : '0;
    end
  end

  // checks
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    top_row <= bottom_row) else $error("span top below bottom");

  a_start_span: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode == pes_pkg::MODE_START |=> top_row == bottom_row)
    else $error("start did not collapse span");

  a_wr_walk: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state == S_WALK) else $error("store write outside walk");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DWT) else $error("divider done while not waited on");

endmodule
`default_nettype wire

[hdl/pes_div.sv]
`default_nettype none
// Restoring divider: 33-bit signed dividend by 10-bit positive divisor,
// one quotient bit per cycle, truncates toward zero.
module pes_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] dividend,
  input  wire logic [9:0]  divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        run;
  logic        neg;
  logic [5:0]  cnt;
  logic [32:0] quo;
  logic [9:0]  rem;
  logic [10:0] sh;
  logic        ge;
  logic [10:0] diff;

  // One trial subtraction per cycle
  assign sh   = {rem, quo[32]};
  assign ge   = sh >= {1'b0, divisor};
  assign diff = sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd33;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[32];
      quo <= dividend[32] ? (33'd0 - dividend) : dividend;
      rem <= '0;
    end else if (run) begin
      rem <= ge ? diff[9:0] : sh[9:0];
      quo <= {quo[31:0], ge};
    end
  end

  assign quotient = neg ? (32'd0 - quo[31:0]) : quo[31:0];

endmodule
`default_nettype wire

[hdl/pes_store.sv]
`default_nettype none
// Left and right per-row stores, one write and one registered read a cycle.
module pes_store #(
  parameter int ROWS    = pes_pkg::ROWS_DEF,
  parameter int COLUMNS = pes_pkg::COLUMNS_DEF
) (
  input  wire logic                  clk,
  input  wire pes_pkg::pes_wr_t      wr,
  input  wire logic [9:0]            wr_row,
  input  wire logic [9:0]            wr_col,
  input  wire logic [31:0]           wr_u,
  input  wire logic [31:0]           wr_v,
  input  wire logic [31:0]           wr_i,
  input  wire logic                  rd_en,
  input  wire logic [9:0]            rd_row,
  output logic [9:0]                 rd_lx,
  output logic [9:0]                 rd_rx,
  output logic [31:0]                rd_lu,
  output logic [31:0]                rd_lv,
  output logic [31:0]                rd_li,
  output logic [31:0]                rd_ru,
  output logic [31:0]                rd_rv,
  output logic [31:0]                rd_ri
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [pes_pkg::EXT_W-1:0] ROW_LIM = pes_pkg::EXT_W'(ROWS);
  localparam logic [pes_pkg::EXT_W-1:0] COL_MAX = pes_pkg::EXT_W'(COLUMNS - 1);

  logic [9:0]  lx_mem [ROWS];
  logic [31:0] lu_mem [ROWS];
  logic [31:0] lv_mem [ROWS];
  logic [31:0] li_mem [ROWS];
  logic [9:0]  rx_mem [ROWS];
  logic [31:0] ru_mem [ROWS];
  logic [31:0] rv_mem [ROWS];
  logic [31:0] ri_mem [ROWS];

  logic [pes_pkg::EXT_W-1:0] wr_ext;
  logic [pes_pkg::EXT_W-1:0] rd_ext;
  logic [pes_pkg::EXT_W-1:0] col_ext;
  logic [AW-1:0]             wa;
  logic [AW-1:0]             ra;
  logic                      wr_ok;
  logic [9:0]                col_sat;

  // Address truncation, row range check and column clamp
  assign wr_ext  = {{(pes_pkg::EXT_W-10){1'b0}}, wr_row};
  assign rd_ext  = {{(pes_pkg::EXT_W-10){1'b0}}, rd_row};
  assign col_ext = {{(pes_pkg::EXT_W-10){1'b0}}, wr_col};
  assign wa      = wr_ext[AW-1:0];
  assign ra      = rd_ext[AW-1:0];
  assign wr_ok   = wr.en && (wr_ext < ROW_LIM);
  assign col_sat = (col_ext > COL_MAX) ? COL_MAX[9:0] : wr_col;

  // Writes
  always_ff @(posedge clk) begin
    if (wr_ok && wr.left) begin
      lx_mem[wa] <= col_sat;
      if (wr.uv) begin
        lu_mem[wa] <= wr_u;
        lv_mem[wa] <= wr_v;
      end
      if (wr.inten) li_mem[wa] <= wr_i;
    end
    if (wr_ok && !wr.left) begin
      rx_mem[wa] <= col_sat;
      if (wr.uv) begin
        ru_mem[wa] <= wr_u;
        rv_mem[wa] <= wr_v;
      end
      if (wr.inten) ri_mem[wa] <= wr_i;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lx <= lx_mem[ra];
      rd_lu <= lu_mem[ra];
      rd_lv <= lv_mem[ra];
      rd_li <= li_mem[ra];
      rd_rx <= rx_mem[ra];
      rd_ru <= ru_mem[ra];
      rd_rv <= rv_mem[ra];
      rd_ri <= ri_mem[ra];
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam logic [pes_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  xs, ys, xe, ye, rr;
    logic [31:0] us, vs, is, ue, ve, ie;
  } edge_word_t;

  typedef struct {
    logic [9:0]  top, bot, lcol, rcol;
    logic [31:0] lu, lv, li, ru, rv, ri;
  } span_word_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic [1:0]  mode = 0;
  logic [9:0]  x_start = 0, y_start = 0, x_end = 0, y_end = 0, read_row = 0;
  logic [31:0] u_start = 0, v_start = 0, i_start = 0, u_end = 0, v_end = 0, i_end = 0;
  logic [9:0]  span_top, span_bottom, left_col, right_col;
  logic [31:0] left_u, left_v, left_i, right_u, right_v, right_i;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  polygon_edge_scanner_unit uut (.*);

  // clock
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // model state
  logic [9:0]  lx_mem[1024], rx_mem[1024];
  logic [31:0] lu_mem[1024], lv_mem[1024], li_mem[1024];
  logic [31:0] ru_mem[1024], rv_mem[1024], ri_mem[1024];
  logic [9:0]  top_row = 0, bottom_row = 0;
  logic [1:0]  attr_sel = 0;
  span_word_t  span_q[$];
  int errors = 0;
  bit idle_en = 1, hold_req = 0;

  function automatic void put_row(bit left, int y, int x, longint u, longint v, longint it);
    logic [9:0] xs;
    xs = (x < 0) ? 10'd0 : (x > 1023 ? 10'd1023 : x[9:0]);
    if (left) begin
      lx_mem[y] = xs;
      if (attr_sel[1]) begin
        lu_mem[y] = u[31:0];
        lv_mem[y] = v[31:0];
      end
      if (attr_sel[0]) li_mem[y] = it[31:0];
    end else begin
      rx_mem[y] = xs;
      if (attr_sel[1]) begin
        ru_mem[y] = u[31:0];
        rv_mem[y] = v[31:0];
      end
      if (attr_sel[0]) ri_mem[y] = it[31:0];
    end
  endfunction

  // Bresenham walk with per-row attribute accumulation
  function automatic void walk_edge(edge_word_t w);
    int x, y, x2, y2, dx, dy, adx, err, sx, sy, major;
    bit left;
    longint u, v, it, du, dv, di;
    x = int'(w.xs); y = int'(w.ys); x2 = int'(w.xe); y2 = int'(w.ye);
    u = longint'($signed(w.us)); v = longint'($signed(w.vs)); it = longint'($signed(w.is));
    du = longint'($signed(w.ue)) - u;
    dv = longint'($signed(w.ve)) - v;
    di = longint'($signed(w.ie)) - it;
    if (w.ye < top_row) top_row = w.ye;
    else if (w.ye > bottom_row) bottom_row = w.ye;
    if (y == y2) return;
    left = (y > y2);
    sy = left ? -1 : 1;
    dy = left ? (y - y2) : (y2 - y);
    dx = x2 - x;
    sx = (dx < 0) ? -1 : 1;
    adx = (dx < 0) ? -dx : dx;
    major = (adx > dy) ? adx : dy;
    du = du / major; dv = dv / major; di = di / major;
    if (adx > dy) begin
      err = adx >>> 1;
      if (left == (dx < 0)) begin
        // last x before the row change
        while (x != x2) begin
          err -= dy;
          if (err < 0) begin
            err += adx;
            put_row(left, y, x, u, v, it);
            y += sy;
          end
          x += sx; u += du; v += dv; it += di;
        end
        put_row(left, y, x, u, v, it);
      end else begin
        // first x after the row change
        put_row(left, y, x, u, v, it);
        while (x != x2) begin
          x += sx; u += du; v += dv; it += di;
          err -= dy;
          if (err < 0) begin
            err += adx;
            y += sy;
            put_row(left, y, x, u, v, it);
          end
        end
      end
    end else begin
      err = dy >>> 1;
      while (y != y2) begin
        put_row(left, y, x, u, v, it);
        err -= adx;
        if (err < 0) begin
          err += dy;
          x += sx;
        end
        y += sy; u += du; v += dv; it += di;
      end
      put_row(left, y, x, u, v, it);
    end
  endfunction

  function automatic void predict_span(edge_word_t w);
    span_word_t r;
    r = '{default: '0};
    case (w.mode)
      pes_pkg::MODE_SCAN:  walk_edge(w);
      pes_pkg::MODE_START: begin
        top_row = w.ys;
        bottom_row = w.ys;
      end
      pes_pkg::MODE_READ: begin
        r.lcol = lx_mem[w.rr]; r.rcol = rx_mem[w.rr];
        r.lu = lu_mem[w.rr]; r.lv = lv_mem[w.rr]; r.li = li_mem[w.rr];
        r.ru = ru_mem[w.rr]; r.rv = rv_mem[w.rr]; r.ri = ri_mem[w.rr];
      end
      default: ;
    endcase
    r.top = top_row;
    r.bot = bottom_row;
    span_q.push_back(r);
  endfunction

  // send one word and predict at acceptance
  task automatic send_word(edge_word_t w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    mode = w.mode; x_start = w.xs; y_start = w.ys; x_end = w.xe; y_end = w.ye;
    u_start = w.us; v_start = w.vs; i_start = w.is;
    u_end = w.ue; v_end = w.ve; i_end = w.ie; read_row = w.rr;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    predict_span(w);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic wait_drained();
    while (span_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_attr(logic [1:0] val);
    wait_drained();
    psel = 1; pwrite = 1; paddr = 3'(pes_pkg::REG_ATTR_SET * 4); pwdata = {30'd0, val};
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    attr_sel = val;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  function automatic edge_word_t make_word(logic [1:0] m, int xs, int ys, int xe, int ye,
                                           logic [31:0] us, logic [31:0] ue, int rr);
    edge_word_t w;
    w.mode = m; w.xs = 10'(xs); w.ys = 10'(ys); w.xe = 10'(xe); w.ye = 10'(ye);
    w.rr = 10'(rr);
    w.us = us; w.vs = ~us; w.is = us ^ 32'h5a5a_a5a5;
    w.ue = ue; w.ve = ~ue; w.ie = ue ^ 32'ha5a5_5a5a;
    return w;
  endfunction

  function automatic int clamp_pix(int v);
    return (v < 0) ? 0 : (v > 1023 ? 1023 : v);
  endfunction

  function automatic edge_word_t rand_word();
    edge_word_t w;
    int pick, span;
    pick = $urandom_range(0, 99);
    w.xs = 10'($urandom); w.ys = 10'($urandom); w.xe = 10'($urandom);
    w.ye = 10'($urandom); w.rr = 10'($urandom);
    w.us = $urandom; w.vs = $urandom; w.is = $urandom;
    w.ue = $urandom; w.ve = $urandom; w.ie = $urandom;
    if (pick < 50) begin
      w.mode = pes_pkg::MODE_SCAN;
      span = ($urandom_range(0, 49) == 0) ? 1023 : 40;
      w.xe = 10'(clamp_pix(int'(w.xs) + $urandom_range(0, 2 * span) - span));
      w.ye = 10'(clamp_pix(int'(w.ys) + $urandom_range(0, 2 * span) - span));
      if ($urandom_range(0, 9) == 0) w.ye = w.ys;
    end else if (pick < 85) w.mode = pes_pkg::MODE_READ;
    else if (pick < 96) w.mode = pes_pkg::MODE_START;
    else w.mode = MODE_UNUSED;
    return w;
  endfunction

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else out_ready = 1;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    span_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (span_q.size() == 0) begin
        $error("unexpected word: span_top %h", span_top);
        errors++;
      end else begin
        e = span_q.pop_front();
        check_field("span_top", 32'(e.top), 32'(span_top));
        check_field("span_bottom", 32'(e.bot), 32'(span_bottom));
        check_field("left_col", 32'(e.lcol), 32'(left_col));
        check_field("right_col", 32'(e.rcol), 32'(right_col));
        check_field("left_u", e.lu, left_u);
        check_field("left_v", e.lv, left_v);
        check_field("left_i", e.li, left_i);
        check_field("right_u", e.ru, right_u);
        check_field("right_v", e.rv, right_v);
        check_field("right_i", e.ri, right_i);
      end
    end
  end

  // directed: fill every row on both sides, then corner cases
  task automatic test_directed();
    write_attr(2'd3);
    send_word(make_word(pes_pkg::MODE_START, 0, 500, 0, 0, 0, 0, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 0, 0, 1023, 1023,
                        32'h8000_0000, 32'h7fff_ffff, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 1023, 1023, 0, 0,
                        32'h7fff_ffff, 32'h8000_0000, 0));
    send_word(make_word(pes_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(pes_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 1023));
    send_word(make_word(pes_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 512));
    send_word(make_word(pes_pkg::MODE_START, 0, 300, 0, 0, 0, 0, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 10, 300, 900, 300, 1, 2, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 100, 200, 160, 190,
                        32'h0001_0000, 32'h0010_0000, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 160, 250, 100, 240,
                        32'hffff_0000, 32'h0003_0000, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 100, 240, 160, 250,
                        32'h0000_1234, 32'hffff_fff0, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 160, 190, 100, 200,
                        32'h1234_5678, 32'h8765_4321, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 0, 190, 1023, 195,
                        32'h8000_0000, 32'h7fff_ffff, 0));
    send_word(make_word(pes_pkg::MODE_SCAN, 5, 400, 6, 390, 0, 32'hffff_ffff, 0));
    send_word(make_word(pes_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 195));
    send_word(make_word(pes_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 245));
    send_word(make_word(MODE_UNUSED, 1023, 1023, 1023, 1023, '1, '1, 1023));
    send_word(make_word(pes_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 395));
  endtask

  task automatic test_random(logic [1:0] attr, int count, bit with_hold);
    write_attr(attr);
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 20) hold_req = 1;
      if (with_hold && n == 60) wait_drained();
      send_word(rand_word());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 0;
    test_directed();
    test_random(2'd0, 130, 1);
    test_random(2'd1, 130, 0);
    test_random(2'd2, 130, 0);
    idle_en = 0;
    test_random(2'd3, 130, 0);
    while (span_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("PASS polygon_edge_scanner_unit");
    else $display("FAIL polygon_edge_scanner_unit");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAIL polygon_edge_scanner_unit");
    $finish;
  end

endmodule
`default_nettype wire
